// ----- src/tbe_pkg.sv -----
`timescale 1ns / 1ps

package tbe_pkg;

  localparam logic [3:0] OP_COND_BRANCH = 4'hD;
  localparam logic [4:0] OP_BRANCH      = 5'h1C;
  localparam logic [4:0] OP_BL_HIGH     = 5'h1E;
  localparam logic [4:0] OP_BL_LOW      = 5'h1F;

  localparam logic [3:0] COND_UNDEF     = 4'hE;
  localparam logic [3:0] COND_SWI       = 4'hF;

  localparam logic [3:0] COND_EQ = 4'h0;
  localparam logic [3:0] COND_NE = 4'h1;
  localparam logic [3:0] COND_CS = 4'h2;
  localparam logic [3:0] COND_CC = 4'h3;
  localparam logic [3:0] COND_MI = 4'h4;
  localparam logic [3:0] COND_PL = 4'h5;
  localparam logic [3:0] COND_VS = 4'h6;
  localparam logic [3:0] COND_VC = 4'h7;
  localparam logic [3:0] COND_HI = 4'h8;
  localparam logic [3:0] COND_LS = 4'h9;
  localparam logic [3:0] COND_GE = 4'hA;
  localparam logic [3:0] COND_LT = 4'hB;
  localparam logic [3:0] COND_GT = 4'hC;
  localparam logic [3:0] COND_LE = 4'hD;

  localparam logic [31:0] SWI_VECTOR = 32'h0000_0008;

  localparam logic [1:0] STATUS_EXEC       = 2'd0;
  localparam logic [1:0] STATUS_UNDEF_COND = 2'd1;
  localparam logic [1:0] STATUS_NOT_BRANCH = 2'd2;

  typedef struct packed {
    logic [15:0] instruction;
    logic [31:0] pc_value;
    logic [31:0] link_value;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic [31:0] psr_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        pc_flush;
    logic [31:0] new_link;
    logic        link_write;
    logic        svc_entry;
    logic [31:0] saved_psr;
    logic        hle_call;
    logic [7:0]  swi_number;
    logic [1:0]  status;
  } out_item_t;

  function automatic logic cond_holds(input logic [3:0] cond, input logic n,
                                      input logic z, input logic c, input logic v);
    logic res;
    unique case (cond)
      COND_EQ: res = z;
      COND_NE: res = !z;
      COND_CS: res = c;
      COND_CC: res = !c;
      COND_MI: res = n;
      COND_PL: res = !n;
      COND_VS: res = v;
      COND_VC: res = !v;
      COND_HI: res = c && !z;
      COND_LS: res = !c || z;
      COND_GE: res = (n == v);
      COND_LT: res = (n != v);
      COND_GT: res = !z && (n == v);
      COND_LE: res = z || (n != v);
      default: res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

// ----- src/tbe_ifs.sv -----
`timescale 1ns / 1ps

interface tbe_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] instruction;
  logic [31:0] pc_value;
  logic [31:0] link_value;
  logic        flag_n;
  logic        flag_z;
  logic        flag_c;
  logic        flag_v;
  logic [31:0] psr_value;

  modport source (output valid, instruction, pc_value, link_value, flag_n, flag_z,
                  flag_c, flag_v, psr_value, input ready);
  modport sink (input valid, instruction, pc_value, link_value, flag_n, flag_z,
                flag_c, flag_v, psr_value, output ready);
endinterface

interface tbe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        pc_flush;
  logic [31:0] new_link;
  logic        link_write;
  logic        svc_entry;
  logic [31:0] saved_psr;
  logic        hle_call;
  logic [7:0]  swi_number;
  logic [1:0]  status;

  modport source (output valid, next_pc, pc_flush, new_link, link_write, svc_entry,
                  saved_psr, hle_call, swi_number, status, input ready);
  modport sink (input valid, next_pc, pc_flush, new_link, link_write, svc_entry,
                saved_psr, hle_call, swi_number, status, output ready);
endinterface

interface tbe_cfg_if;
  logic valid;
  logic ready;
  logic use_hle;

  modport source (output valid, use_hle, input ready);
  modport sink (input valid, use_hle, output ready);
endinterface

// ----- src/thumb_branch_execute.sv -----
`timescale 1ns / 1ps

// Thumb branch execute unit: conditional branch, unconditional branch, both halves of
// BL and SWI (exception entry, or a high-level call when use_hle is set). Each item
// yields exactly one result. An accepted item is captured in an input register, decoded
// and added in one pass, and stored in the result register once that register is free
// or being read; the result register drives the output. One item per cycle is sustained
// while the result side is ready. The result register and input register each hold one
// item, so a new item is still taken while a finished result waits, as long as the input
// register is empty. The use_hle register is written through the cfg channel, which
// is always ready, and should change only while the unit is empty.
module thumb_branch_execute (
  input  logic      clk,
  input  logic      rst_n,
  tbe_in_if.sink    in_chan,
  tbe_out_if.source out_chan,
  tbe_cfg_if.sink   cfg_chan
);
  import tbe_pkg::*;

  logic      use_hle_r;
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;
  out_item_t res_nxt;

  logic        in_acc;
  logic        s2_take;
  logic [31:0] add_base;
  logic [31:0] add_off;
  logic [31:0] add_sum;
  logic [31:0] pc_plus2;
  logic [31:0] pc_minus2;
  logic [3:0]  cond;
  logic [4:0]  top5;

  assign s2_take        = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = !s1_valid_r || s2_take;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s2_take);
  assign out_valid_nxt = s2_take ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_hle_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        use_hle_r <= cfg_chan.use_hle;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.instruction <= in_chan.instruction;
      s1_item_r.pc_value    <= in_chan.pc_value;
      s1_item_r.link_value  <= in_chan.link_value;
      s1_item_r.flag_n      <= in_chan.flag_n;
      s1_item_r.flag_z      <= in_chan.flag_z;
      s1_item_r.flag_c      <= in_chan.flag_c;
      s1_item_r.flag_v      <= in_chan.flag_v;
      s1_item_r.psr_value   <= in_chan.psr_value;
    end
    if (s2_take && s1_valid_r) begin
      out_item_r <= res_nxt;
    end
  end

  assign cond      = s1_item_r.instruction[11:8];
  assign top5      = s1_item_r.instruction[15:11];
  assign pc_plus2  = s1_item_r.pc_value + 32'd2;
  assign pc_minus2 = s1_item_r.pc_value - 32'd2;

  // One shared adder forms every branch target but the SWI vector, and the first BL half link value.
  always_comb begin
    add_base = s1_item_r.pc_value;
    add_off  = {{23{s1_item_r.instruction[7]}}, s1_item_r.instruction[7:0], 1'b0};
    case (top5)
      OP_BRANCH: begin
        add_off = {{20{s1_item_r.instruction[10]}}, s1_item_r.instruction[10:0], 1'b0};
      end
      OP_BL_HIGH: begin
        add_off = {{9{s1_item_r.instruction[10]}}, s1_item_r.instruction[10:0], 12'b0};
      end
      OP_BL_LOW: begin
        add_base = s1_item_r.link_value;
        add_off  = {20'b0, s1_item_r.instruction[10:0], 1'b0};
      end
      default: ;
    endcase
  end

  assign add_sum = add_base + add_off;

  always_comb begin
    res_nxt            = '0;
    res_nxt.next_pc    = s1_item_r.pc_value;
    res_nxt.status     = STATUS_EXEC;
    if (s1_item_r.instruction[15:12] == OP_COND_BRANCH) begin
      if (cond == COND_SWI) begin
        res_nxt.swi_number = s1_item_r.instruction[7:0];
        if (use_hle_r) begin
          res_nxt.hle_call = 1'b1;
          res_nxt.next_pc  = pc_plus2;
        end else begin
          res_nxt.svc_entry  = 1'b1;
          res_nxt.saved_psr  = s1_item_r.psr_value;
          res_nxt.new_link   = pc_minus2;
          res_nxt.link_write = 1'b1;
          res_nxt.next_pc    = SWI_VECTOR;
          res_nxt.pc_flush   = 1'b1;
        end
      end else if (cond == COND_UNDEF) begin
        res_nxt.status = STATUS_UNDEF_COND;
      end else if (cond_holds(cond, s1_item_r.flag_n, s1_item_r.flag_z,
                              s1_item_r.flag_c, s1_item_r.flag_v)) begin
        res_nxt.next_pc  = add_sum;
        res_nxt.pc_flush = 1'b1;
      end else begin
        res_nxt.next_pc = pc_plus2;
      end
    end else begin
      unique case (top5)
        OP_BRANCH: begin
          res_nxt.next_pc  = add_sum;
          res_nxt.pc_flush = 1'b1;
        end
        OP_BL_HIGH: begin
          res_nxt.new_link   = add_sum;
          res_nxt.link_write = 1'b1;
          res_nxt.next_pc    = pc_plus2;
        end
        OP_BL_LOW: begin
          res_nxt.next_pc    = add_sum;
          res_nxt.pc_flush   = 1'b1;
          res_nxt.new_link   = {pc_minus2[31:1], 1'b1};
          res_nxt.link_write = 1'b1;
        end
        default: begin
          res_nxt.status = STATUS_NOT_BRANCH;
        end
      endcase
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.next_pc    = out_item_r.next_pc;
  assign out_chan.pc_flush   = out_item_r.pc_flush;
  assign out_chan.new_link   = out_item_r.new_link;
  assign out_chan.link_write = out_item_r.link_write;
  assign out_chan.svc_entry  = out_item_r.svc_entry;
  assign out_chan.saved_psr  = out_item_r.saved_psr;
  assign out_chan.hle_call   = out_item_r.hle_call;
  assign out_chan.swi_number = out_item_r.swi_number;
  assign out_chan.status     = out_item_r.status;

  // Supervisor entry always redirects the fetch and saves the return address.
  a_svc_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.svc_entry |-> out_item_r.pc_flush && out_item_r.link_write)
    else $error("svc entry without flush or link write");

  // A high-level call never also takes the exception.
  a_hle_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.hle_call |-> !out_item_r.svc_entry && !out_item_r.pc_flush)
    else $error("hle call combined with exception entry");

  // An item that was not executed leaves the fetch and the link register alone.
  a_status_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.status != STATUS_EXEC) |->
      !out_item_r.pc_flush && !out_item_r.link_write)
    else $error("non-executed item changed pc or link");

  // A held item in the input register is not lost while the result side stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_take |=> s1_valid_r && out_valid_r)
    else $error("input register dropped a stalled item");

endmodule

// ----- test/thumb_branch_execute_tb.sv -----
`timescale 1ns / 1ps

module thumb_branch_execute_tb;
  import tbe_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 290;
  localparam int NUM_PHASES = 6;
  localparam logic [4:0] OP_BLX_SUFFIX = 5'h1D;

  class branch_scoreboard;
    logic use_hle;
    out_item_t pending_results[$];
    int errors;
    int checked;
    int taken_jumps;
    int svc_swis;
    int hle_swis;
    int undef_conds;
    int non_branches;

    function new();
      use_hle = 1'b0;
      errors = 0;
      checked = 0;
      taken_jumps = 0;
      svc_swis = 0;
      hle_swis = 0;
      undef_conds = 0;
      non_branches = 0;
    endfunction

    // The low bit of a condition code inverts the test named by the pair.
    function logic cond_met(logic [3:0] cond, logic n, logic z, logic c, logic v);
      logic base;
      case (cond)
        COND_EQ, COND_NE: base = z;
        COND_CS, COND_CC: base = c;
        COND_MI, COND_PL: base = n;
        COND_VS, COND_VC: base = v;
        COND_HI, COND_LS: base = c & ~z;
        COND_GE, COND_LT: base = ~(n ^ v);
        COND_GT, COND_LE: base = ~z & ~(n ^ v);
        default: base = 1'b1;
      endcase
      return base ^ cond[0];
    endfunction

    function out_item_t resolve_branch(in_item_t it);
      out_item_t r;
      logic [3:0] cond;
      logic [10:0] off11;
      logic [31:0] sext11;
      logic [31:0] sext8;
      r = '0;
      r.next_pc = it.pc_value;
      r.status = STATUS_EXEC;
      off11 = it.instruction[10:0];
      sext11 = {{21{off11[10]}}, off11};
      sext8 = {{24{it.instruction[7]}}, it.instruction[7:0]};
      cond = it.instruction[11:8];
      if (it.instruction[15:12] == OP_COND_BRANCH) begin
        if (cond == COND_SWI) begin
          r.swi_number = it.instruction[7:0];
          if (use_hle) begin
            r.hle_call = 1'b1;
            r.next_pc = it.pc_value + 32'd2;
          end else begin
            r.svc_entry = 1'b1;
            r.saved_psr = it.psr_value;
            r.new_link = it.pc_value - 32'd2;
            r.link_write = 1'b1;
            r.next_pc = SWI_VECTOR;
            r.pc_flush = 1'b1;
          end
        end else if (cond == COND_UNDEF) begin
          r.status = STATUS_UNDEF_COND;
        end else if (cond_met(cond, it.flag_n, it.flag_z, it.flag_c, it.flag_v)) begin
          r.next_pc = it.pc_value + (sext8 << 1);
          r.pc_flush = 1'b1;
        end else begin
          r.next_pc = it.pc_value + 32'd2;
        end
      end else begin
        case (it.instruction[15:11])
          OP_BRANCH: begin
            r.next_pc = it.pc_value + (sext11 << 1);
            r.pc_flush = 1'b1;
          end
          OP_BL_HIGH: begin
            r.new_link = it.pc_value + (sext11 << 12);
            r.link_write = 1'b1;
            r.next_pc = it.pc_value + 32'd2;
          end
          OP_BL_LOW: begin
            r.next_pc = it.link_value + ({21'd0, off11} << 1);
            r.pc_flush = 1'b1;
            r.new_link = (it.pc_value - 32'd2) | 32'd1;
            r.link_write = 1'b1;
          end
          default: r.status = STATUS_NOT_BRANCH;
        endcase
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      r = resolve_branch(it);
      if (r.pc_flush && !r.svc_entry) taken_jumps++;
      if (r.svc_entry) svc_swis++;
      if (r.hle_call) hle_swis++;
      if (r.status == STATUS_UNDEF_COND) undef_conds++;
      if (r.status == STATUS_NOT_BRANCH) non_branches++;
      pending_results.push_back(r);
    endfunction

    function void field_check(string field, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch on %s at result %0d: expected %h, got %h",
                   field, checked, exp, act);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result item: next_pc %h", got.next_pc);
        return;
      end
      e = pending_results.pop_front();
      field_check("next_pc", e.next_pc, got.next_pc);
      field_check("pc_flush", 32'(e.pc_flush), 32'(got.pc_flush));
      field_check("new_link", e.new_link, got.new_link);
      field_check("link_write", 32'(e.link_write), 32'(got.link_write));
      field_check("svc_entry", 32'(e.svc_entry), 32'(got.svc_entry));
      field_check("saved_psr", e.saved_psr, got.saved_psr);
      field_check("hle_call", 32'(e.hle_call), 32'(got.hle_call));
      field_check("swi_number", 32'(e.swi_number), 32'(got.swi_number));
      field_check("status", 32'(e.status), 32'(got.status));
      checked++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int cycles;
  int items_sent;
  int hle_writes;
  bit send_idle;
  bit recv_idle;
  branch_scoreboard sb;

  tbe_in_if in_if ();
  tbe_out_if out_if ();
  tbe_cfg_if cfg_if ();

  thumb_branch_execute dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", sb.pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    gap = send_idle ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.instruction <= it.instruction;
    in_if.pc_value <= it.pc_value;
    in_if.link_value <= it.link_value;
    in_if.flag_n <= it.flag_n;
    in_if.flag_z <= it.flag_z;
    in_if.flag_c <= it.flag_c;
    in_if.flag_v <= it.flag_v;
    in_if.psr_value <= it.psr_value;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  task automatic write_use_hle(logic value);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.use_hle <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.use_hle = value;
    hle_writes++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'hFFFF_FFFE;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_item(logic [15:0] ins, logic [31:0] pc, logic [31:0] lr,
                                         logic [3:0] nzcv, logic [31:0] psr);
    in_item_t it;
    it.instruction = ins;
    it.pc_value = pc;
    it.link_value = lr;
    {it.flag_n, it.flag_z, it.flag_c, it.flag_v} = nzcv;
    it.psr_value = psr;
    return it;
  endfunction

  function automatic in_item_t random_item(logic [15:0] ins);
    return make_item(ins, pick_word(), pick_word(), 4'($urandom_range(0, 15)), $urandom);
  endfunction

  task automatic send_random_group();
    in_item_t first;
    in_item_t second;
    logic [10:0] off;
    int kind;
    kind = $urandom_range(0, 99);
    off = 11'($urandom);
    if (kind < 35) begin
      send_item(random_item({OP_COND_BRANCH, 4'($urandom_range(0, 15)), off[7:0]}));
    end else if (kind < 50) begin
      send_item(random_item({OP_BRANCH, off}));
    end else if (kind < 72) begin
      // A BL pair, or one half alone: the second half sits two bytes on and sees the link set by the first.
      first = random_item({OP_BL_HIGH, off});
      second = random_item({OP_BL_LOW, 11'($urandom)});
      second.pc_value = first.pc_value + 32'd2;
      second.link_value = first.pc_value + ({{21{off[10]}}, off} << 12);
      case ($urandom_range(0, 5))
        0: send_item(first);
        1: send_item(second);
        default: begin
          send_item(first);
          send_item(second);
        end
      endcase
    end else if (kind < 82) begin
      send_item(random_item({OP_COND_BRANCH, COND_SWI, off[7:0]}));
    end else if (kind < 88) begin
      send_item(random_item({OP_BLX_SUFFIX, off}));
    end else begin
      send_item(random_item(16'($urandom)));
    end
  endtask

  initial begin
    out_item_t got;
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = recv_idle ? $urandom_range(0, 18) : 0;
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.next_pc = out_if.next_pc;
      got.pc_flush = out_if.pc_flush;
      got.new_link = out_if.new_link;
      got.link_write = out_if.link_write;
      got.svc_entry = out_if.svc_entry;
      got.saved_psr = out_if.saved_psr;
      got.hle_call = out_if.hle_call;
      got.swi_number = out_if.swi_number;
      got.status = out_if.status;
      sb.check_result(got);
    end
  end

  initial begin
    int sent_before;
    int mark;
    sb = new();
    items_sent = 0;
    hle_writes = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.instruction <= '0;
    in_if.pc_value <= '0;
    in_if.link_value <= '0;
    in_if.flag_n <= 1'b0;
    in_if.flag_z <= 1'b0;
    in_if.flag_c <= 1'b0;
    in_if.flag_v <= 1'b0;
    in_if.psr_value <= '0;
    out_if.ready <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.use_hle <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int c = 0; c < 14; c++)
      send_item(random_item({OP_COND_BRANCH, 4'(c), c[0] ? 8'h80 : 8'h7F}));
    send_item(random_item({OP_COND_BRANCH, COND_UNDEF, 8'hFF}));
    send_item(make_item({OP_COND_BRANCH, COND_SWI, 8'hFF}, 32'h0, 32'hFFFF_FFFF, 4'hF,
                        32'hFFFF_FFFF));
    send_item(make_item({OP_COND_BRANCH, COND_SWI, 8'h00}, 32'hFFFF_FFFF, 32'h0, 4'h0,
                        32'h0));
    send_item(make_item({OP_BRANCH, 11'h3FF}, 32'hFFFF_FFFE, 32'h0, 4'h0, 32'h0));
    send_item(make_item({OP_BRANCH, 11'h400}, 32'h0, 32'h0, 4'h0, 32'h0));
    send_item(make_item({OP_BL_HIGH, 11'h400}, 32'h0, 32'h0, 4'h0, 32'h0));
    send_item(make_item({OP_BL_HIGH, 11'h3FF}, 32'hFFFF_FFFF, 32'h0, 4'h0, 32'h0));
    send_item(make_item({OP_BL_LOW, 11'h7FF}, 32'h0, 32'hFFFF_FFFF, 4'h0, 32'h0));
    send_item(make_item({OP_BL_LOW, 11'h000}, 32'h1, 32'h0, 4'h0, 32'h0));
    send_item(random_item({OP_BLX_SUFFIX, 11'h5A5}));
    send_item(random_item(16'h0000));
    write_use_hle(1'b1);
    send_item(random_item({OP_COND_BRANCH, COND_SWI, 8'hA5}));
    send_item(random_item({OP_COND_BRANCH, COND_SWI, 8'h5A}));

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_use_hle(p[0]);
      sent_before = items_sent;
      mark = items_sent;
      while (items_sent - sent_before < PHASE_ITEMS) begin
        if (items_sent - mark >= 40) begin
          mark = items_sent;
          send_idle = ($urandom_range(0, 3) != 0);
          recv_idle = ($urandom_range(0, 3) != 0);
        end
        if (items_sent - sent_before >= PHASE_ITEMS / 2 &&
            items_sent - sent_before < PHASE_ITEMS / 2 + 3)
          wait_drained();
        send_random_group();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d instructions over %0d use_hle writes; %0d results checked.",
             items_sent, hle_writes, sb.checked);
    $display("Seen: %0d taken jumps, %0d SWI entries, %0d HLE calls, %0d cond 0xE, %0d other.",
             sb.taken_jumps, sb.svc_swis, sb.hle_swis, sb.undef_conds, sb.non_branches);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing.", sb.errors, sb.pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
